/* design/xbm_pkg.sv */
`timescale 1ns / 1ps
package xbm_pkg;

  localparam int VALUE_W = 63;
  localparam int RANK_W  = 6;
  localparam int WORD_W  = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_RUN,
    ST_MAX_RD,
    ST_MAX_RUN,
    ST_DONE
  } state_e;

  typedef enum logic {
    OP_INSERT,
    OP_MAX
  } op_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic step;
    op_e  op;
  } xbm_ctrl_t;

endpackage

/* design/xbm_ram.sv */
`timescale 1ns / 1ps
module xbm_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 63,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/xbm_reduce.sv */
`timescale 1ns / 1ps
module xbm_reduce import xbm_pkg::*; #(
  parameter int BIT_WIDTH = 63,
  localparam int IDX_W = $clog2(BIT_WIDTH)
) (
  input  logic                 clk_i,
  input  xbm_ctrl_t            ctrl_i,
  input  logic [BIT_WIDTH-1:0] value_i,
  input  logic [IDX_W-1:0]     bit_i,
  input  logic [BIT_WIDTH-1:0] slot_i,
  input  logic                 slot_vld_i,
  output logic                 store_o,
  output logic [BIT_WIDTH-1:0] acc_o
);

  logic [BIT_WIDTH-1:0] acc_q, acc_d;
  logic [BIT_WIDTH-1:0] slot_eff;
  logic                 acc_bit;

  assign slot_eff = slot_vld_i ? slot_i : '0;
  assign acc_bit  = acc_q[bit_i];
  assign store_o  = ctrl_i.step && (ctrl_i.op == OP_INSERT) && acc_bit && !slot_vld_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = value_i;
    end else if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      case (ctrl_i.op)
        OP_INSERT: if (acc_bit) acc_d = acc_q ^ slot_eff;
        OP_MAX:    if (!acc_bit) acc_d = acc_q ^ slot_eff;
        default:   acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* design/xbm_ctrl.sv */
`timescale 1ns / 1ps
module xbm_ctrl import xbm_pkg::*; #(
  parameter int BIT_WIDTH = 63,
  localparam int IDX_W  = $clog2(BIT_WIDTH),
  localparam int RANK_CW = $clog2(BIT_WIDTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_i,
  input  logic               store_i,
  input  logic               out_free_i,
  output logic               in_stall_o,
  output xbm_ctrl_t          ctrl_o,
  output logic [IDX_W-1:0]   bit_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic               we_o,
  output logic               slot_vld_o,
  output logic [RANK_CW-1:0] rank_o,
  output logic               out_load_o
);

  localparam logic [IDX_W-1:0] TOP = IDX_W'(BIT_WIDTH - 1);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     b_q, b_d;
  logic                 last_q, last_d;
  logic [BIT_WIDTH-1:0] valid_q, valid_d;
  logic [RANK_CW-1:0]   rank_q, rank_d;
  logic                 accept;
  logic                 ins_end;
  logic                 running;

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign ins_end = (state_q == ST_INS_RUN) && (store_i || (b_q == '0));
  assign running = (state_q == ST_INS_RUN) || (state_q == ST_MAX_RUN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_INS_RD;
      ST_INS_RD:  state_d = ST_INS_RUN;
      ST_INS_RUN: if (ins_end) state_d = last_q ? ST_MAX_RD : ST_IDLE;
      ST_MAX_RD:  state_d = ST_MAX_RUN;
      ST_MAX_RUN: if (b_q == '0) state_d = ST_DONE;
      ST_DONE:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    ctrl_o.load = accept;
    ctrl_o.clr  = (state_q == ST_MAX_RD);
    ctrl_o.step = running;
    ctrl_o.op   = (state_q == ST_MAX_RUN) ? OP_MAX : OP_INSERT;
    we_o        = (state_q == ST_INS_RUN) && store_i;
    out_load_o  = (state_q == ST_DONE) && out_free_i;
    rd_addr_o   = (running && (b_q != '0)) ? b_q - 1'b1 : b_q;
  end

  always_comb begin
    b_d     = b_q;
    last_d  = last_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (accept) begin
      last_d = last_i;
    end
    if (accept || ins_end) begin
      b_d = TOP;
    end else if (running && (b_q != '0)) begin
      b_d = b_q - 1'b1;
    end
    if (we_o) begin
      valid_d[b_q] = 1'b1;
      rank_d       = rank_q + 1'b1;
    end
    if (out_load_o) begin
      valid_d = '0;
      rank_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      b_q     <= TOP;
      last_q  <= 1'b0;
      valid_q <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      b_q     <= b_d;
      last_q  <= last_d;
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  assign bit_o      = b_q;
  assign slot_vld_o = valid_q[b_q];
  assign rank_o     = rank_q;

  a_write_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> !valid_q[b_q])
    else $error("basis write to occupied slot");

  a_rank_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(rank_q))
    else $error("rank does not match occupied slots");

  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> (valid_q == '0) && (state_q == ST_IDLE))
    else $error("basis not cleared after result");

  a_store_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_i |-> (state_q == ST_INS_RUN))
    else $error("store outside insertion walk");

endmodule

/* design/xor_basis_max_subset_xor_top.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | value_i, last_i
// out     | output    | out_valid_o/out_stall_i | max_xor_o, basis_rank_o
// an insert walks down the slots, one basis slot per cycle through one ram read port
// a request with last set is followed by the max scan and the result load
// in_stall_o is high from the accepting edge until the controller is back in idle
// a pending result in the output register blocks only the next result load, stalling input while it waits
// reset empties the basis at once through per-slot valid bits
module xor_basis_max_subset_xor_top import xbm_pkg::*; #(
  parameter int BIT_WIDTH = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] max_xor_o,
  output logic [RANK_W-1:0]  basis_rank_o
);

  localparam int IDX_W   = $clog2(BIT_WIDTH);
  localparam int RANK_CW = $clog2(BIT_WIDTH + 1);

  xbm_ctrl_t            ctrl;
  logic [IDX_W-1:0]     bit_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 we;
  logic                 slot_vld;
  logic [RANK_CW-1:0]   rank;
  logic                 out_load;
  logic                 out_free;
  logic                 store;
  logic [BIT_WIDTH-1:0] acc;
  logic [BIT_WIDTH-1:0] slot;
  logic [WORD_W-1:0]    value_w;
  logic [WORD_W-1:0]    acc_w;
  logic [WORD_W-1:0]    rank_w;
  logic                 out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]   max_xor_q;
  logic [RANK_W-1:0]    basis_rank_q;

  assign value_w  = WORD_W'(value_i);
  assign acc_w    = WORD_W'(acc);
  assign rank_w   = WORD_W'(rank);
  assign out_free = !out_valid_q || !out_stall_i;

  xbm_ctrl #(.BIT_WIDTH(BIT_WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .store_i    (store),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl),
    .bit_o      (bit_idx),
    .rd_addr_o  (rd_addr),
    .we_o       (we),
    .slot_vld_o (slot_vld),
    .rank_o     (rank),
    .out_load_o (out_load)
  );

  xbm_reduce #(.BIT_WIDTH(BIT_WIDTH)) u_reduce (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .value_i    (value_w[BIT_WIDTH-1:0]),
    .bit_i      (bit_idx),
    .slot_i     (slot),
    .slot_vld_i (slot_vld),
    .store_o    (store),
    .acc_o      (acc)
  );

  xbm_ram #(.WIDTH(BIT_WIDTH), .DEPTH(BIT_WIDTH)) u_basis_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (bit_idx),
    .wdata_i (acc),
    .raddr_i (rd_addr),
    .rdata_o (slot)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      max_xor_q    <= acc_w[VALUE_W-1:0];
      basis_rank_q <= rank_w[RANK_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_xor_o    = max_xor_q;
  assign basis_rank_o = basis_rank_q;

endmodule
